### sv/kpe_pkg.sv
package kpe_pkg;

  localparam int MAX_DIGITS = 64;
  localparam int ADDR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int TICK_W = 20;
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(60000);

  localparam logic [1:0] REQ_KEY = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;
  localparam logic [1:0] REQ_ABORT = 2'd3;

  localparam logic [15:0] EV_KEY = 16'd1;
  localparam logic [1:0] KEY_PRESS = 2'd1;

  localparam logic [15:0] KEY_ESC = 16'd1;
  localparam logic [15:0] KEY_BKSP = 16'd14;
  localparam logic [15:0] KEY_RETURN = 16'd28;
  localparam logic [15:0] KEY_KP_ENTER = 16'd96;

  localparam logic [1:0] OUT_DIGIT = 2'd0;
  localparam logic [1:0] OUT_EMPTY = 2'd1;
  localparam logic [1:0] OUT_FAIL = 2'd2;

  localparam logic [1:0] FAIL_NONE = 2'd0;
  localparam logic [1:0] FAIL_ESC = 2'd1;
  localparam logic [1:0] FAIL_TOO_LONG = 2'd2;
  localparam logic [1:0] FAIL_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [15:0] event_type;
    logic [15:0] key_code;
    logic [1:0] key_value;
  } req_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic [3:0] digit;
    logic [1:0] fail_reason;
    logic last;
  } res_t;

  typedef struct packed {
    logic hit;
    logic [3:0] value;
  } key_digit_t;

  typedef struct packed {
    logic wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [3:0] wr_data;
    logic drain_start;
    logic [CNT_W-1:0] drain_count;
  } store_cmd_t;

  typedef struct packed {
    logic valid;
    logic [3:0] digit;
    logic last;
  } drain_out_t;

  function automatic key_digit_t key_digit(input logic [15:0] code);
    key_digit_t r;
    r.hit = 1'b1;
    r.value = 4'd0;
    case (code)
      16'd2: r.value = 4'd1;
      16'd3: r.value = 4'd2;
      16'd4: r.value = 4'd3;
      16'd5: r.value = 4'd4;
      16'd6: r.value = 4'd5;
      16'd7: r.value = 4'd6;
      16'd8: r.value = 4'd7;
      16'd9: r.value = 4'd8;
      16'd10: r.value = 4'd9;
      16'd11: r.value = 4'd0;
      16'd71: r.value = 4'd7;
      16'd72: r.value = 4'd8;
      16'd73: r.value = 4'd9;
      16'd75: r.value = 4'd4;
      16'd76: r.value = 4'd5;
      16'd77: r.value = 4'd6;
      16'd79: r.value = 4'd1;
      16'd80: r.value = 4'd2;
      16'd81: r.value = 4'd3;
      16'd82: r.value = 4'd0;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### sv/kpe_store.sv
module kpe_store (
  input  logic                clk,
  input  logic                rst,
  input  kpe_pkg::store_cmd_t cmd,
  output kpe_pkg::drain_out_t drain,
  output logic                drain_busy
);
  import kpe_pkg::*;

  logic [3:0] mem [MAX_DIGITS];
  logic [3:0] rd_data;
  logic active;
  logic pend;
  logic pend_last;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] rd_count;
  logic rd_last;

  assign rd_last = (rd_idx + CNT_W'(1)) == rd_count;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    rd_data <= mem[rd_idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pend <= 1'b0;
      pend_last <= 1'b0;
      rd_idx <= '0;
      rd_count <= '0;
    end else begin
      pend <= active;
      pend_last <= active && rd_last;
      if (cmd.drain_start) begin
        active <= 1'b1;
        rd_idx <= '0;
        rd_count <= cmd.drain_count;
      end else if (active) begin
        rd_idx <= rd_idx + CNT_W'(1);
        if (rd_last) begin
          active <= 1'b0;
        end
      end
    end
  end

  assign drain.valid = pend;
  assign drain.digit = rd_data;
  assign drain.last = pend_last;
  assign drain_busy = active || pend;

  assert property (@(posedge clk) disable iff (rst) cmd.drain_start |=> active);
  assert property (@(posedge clk) disable iff (rst) active |-> rd_idx < rd_count)
    else $error("drain index ran past the stored count");
  assert property (@(posedge clk) disable iff (rst) pend_last |-> pend)
    else $error("last flag without a pending read");

endmodule

### sv/keypad_pin_entry.sv
// A request is taken when start is high and busy is low. Start, abort, tick and most key
// requests finish in the cycle they are taken; a result they cause is on the result port
// for one cycle right after. Enter with N stored digits keeps busy high while the digits drain
// and puts out one digit per cycle through the drain active flag, the registered memory read
// and the result register, paced by the single read port of the digit memory. The receiver
// cannot stall, and the digit memory needs no clearing pass after reset.
module keypad_pin_entry (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  kpe_pkg::req_t         req,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [19:0]           cfg_data,
  output logic                  result_valid,
  output kpe_pkg::res_t         result
);
  import kpe_pkg::*;

  logic session_active;
  logic session_active_next;
  logic [CNT_W-1:0] digit_count;
  logic [CNT_W-1:0] digit_count_next;
  logic [TICK_W-1:0] elapsed_ticks;
  logic [TICK_W-1:0] elapsed_ticks_next;
  logic [TICK_W-1:0] tick_inc;
  logic [TICK_W-1:0] timeout_ticks;
  logic fire;
  logic res_set;
  res_t res_next;
  key_digit_t kd;
  store_cmd_t cmd;
  drain_out_t drain;
  logic drain_busy;

  assign cfg_ready = 1'b1;
  assign busy = drain_busy;
  assign fire = start && !busy;
  assign kd = key_digit(req.key_code);
  assign tick_inc = (elapsed_ticks < TICK_MAX) ? elapsed_ticks + TICK_W'(1) : elapsed_ticks;

  always_comb begin
    session_active_next = session_active;
    digit_count_next = digit_count;
    elapsed_ticks_next = elapsed_ticks;
    res_set = 1'b0;
    res_next = '{outcome: OUT_FAIL, digit: 4'd0, fail_reason: FAIL_NONE, last: 1'b1};
    cmd = '0;
    cmd.wr_addr = digit_count[ADDR_W-1:0];
    cmd.wr_data = kd.value;
    cmd.drain_count = digit_count;
    if (fire) begin
      if (req.req_type == REQ_START) begin
        session_active_next = 1'b1;
        digit_count_next = '0;
        elapsed_ticks_next = '0;
      end else if (session_active) begin
        case (req.req_type)
          REQ_ABORT: begin
            session_active_next = 1'b0;
            digit_count_next = '0;
            elapsed_ticks_next = '0;
          end
          REQ_TICK: begin
            elapsed_ticks_next = tick_inc;
            if (tick_inc >= timeout_ticks) begin
              res_set = 1'b1;
              res_next.fail_reason = FAIL_TIMEOUT;
              session_active_next = 1'b0;
              digit_count_next = '0;
              elapsed_ticks_next = '0;
            end
          end
          default: begin
            if (req.event_type == EV_KEY && req.key_value == KEY_PRESS) begin
              if (req.key_code == KEY_BKSP) begin
                if (digit_count != '0) begin
                  digit_count_next = digit_count - CNT_W'(1);
                end
              end else if (req.key_code == KEY_RETURN || req.key_code == KEY_KP_ENTER) begin
                if (digit_count == '0) begin
                  res_set = 1'b1;
                  res_next.outcome = OUT_EMPTY;
                end else begin
                  cmd.drain_start = 1'b1;
                end
                session_active_next = 1'b0;
                digit_count_next = '0;
                elapsed_ticks_next = '0;
              end else if (req.key_code == KEY_ESC) begin
                res_set = 1'b1;
                res_next.fail_reason = FAIL_ESC;
                session_active_next = 1'b0;
                digit_count_next = '0;
                elapsed_ticks_next = '0;
              end else if (kd.hit) begin
                if (digit_count >= CNT_W'(MAX_DIGITS)) begin
                  res_set = 1'b1;
                  res_next.fail_reason = FAIL_TOO_LONG;
                  session_active_next = 1'b0;
                  digit_count_next = '0;
                  elapsed_ticks_next = '0;
                end else begin
                  cmd.wr_en = 1'b1;
                  digit_count_next = digit_count + CNT_W'(1);
                end
              end
            end
          end
        endcase
      end
    end
    if (drain.valid) begin
      res_set = 1'b1;
      res_next = '{outcome: OUT_DIGIT, digit: drain.digit, fail_reason: FAIL_NONE,
                   last: drain.last};
    end
  end

  kpe_store u_store (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .drain      (drain),
    .drain_busy (drain_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      session_active <= 1'b0;
      digit_count <= '0;
      elapsed_ticks <= '0;
      timeout_ticks <= TIMEOUT_RESET;
      result_valid <= 1'b0;
    end else begin
      session_active <= session_active_next;
      digit_count <= digit_count_next;
      elapsed_ticks <= elapsed_ticks_next;
      if (cfg_valid && cfg_ready) begin
        timeout_ticks <= cfg_data;
      end
      result_valid <= res_set;
    end
  end

  always_ff @(posedge clk) begin
    if (res_set) begin
      result <= res_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) busy |-> !session_active)
    else $error("session open while digits drain");
  assert property (@(posedge clk) disable iff (rst) digit_count <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond capacity");
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.outcome != OUT_DIGIT |-> result.last)
    else $error("single result without last mark");
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.outcome == OUT_FAIL) == (result.fail_reason != FAIL_NONE))
    else $error("fail reason does not match outcome");
  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> result_valid && result.last)
    else $error("drain ended without a final digit");

endmodule
